[hdl/bcpe_pkg.sv]
package bcpe_pkg;

	localparam int MAX_POINTS = 8;
	localparam int T_BITS = 16;
	localparam int COORD_W = 32;
	localparam int AXES = 3;
	localparam int PC_W = 4;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int LEN_W = $clog2(MAX_POINTS + 1);

	localparam logic [PC_W-1:0] PC_RESET = PC_W'(4);

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	// Axis 0 is x, axis 1 is y, axis 2 is z.
	typedef logic [AXES-1:0][COORD_W-1:0] coord_vec_t;

	typedef struct packed {
		logic             idle;
		logic             step;
		logic             last;
		logic [IDX_W-1:0] wr_idx;
		logic             done;
	} ctrl_t;

endpackage

[hdl/bcpe_lerp.sv]
module bcpe_lerp (
	input  bcpe_pkg::coord_vec_t          p,
	input  bcpe_pkg::coord_vec_t          q,
	input  logic [bcpe_pkg::T_BITS-1:0]   t,
	output bcpe_pkg::coord_vec_t          res
);

	localparam int CW = bcpe_pkg::COORD_W;
	localparam int TW = bcpe_pkg::T_BITS;
	localparam int PROD_W = CW + TW + 2;
	localparam int SUM_W = PROD_W - TW;

	logic signed [CW:0]       diff_v [bcpe_pkg::AXES];
	logic signed [PROD_W-1:0] prod_v [bcpe_pkg::AXES];
	logic signed [SUM_W-1:0]  sum_v  [bcpe_pkg::AXES];
	logic signed [TW:0]       t_s;

	assign t_s = signed'({1'b0, t});

	// The arithmetic right shift of the product is the floor of the quotient,
	// and the sum always lies between p and q, so it fits the coordinate width.
	always_comb begin
		for (int a = 0; a < bcpe_pkg::AXES; a++) begin
			diff_v[a] = signed'({q[a][CW-1], q[a]}) - signed'({p[a][CW-1], p[a]});
			prod_v[a] = diff_v[a] * t_s;
			sum_v[a] = prod_v[a][PROD_W-1:TW]
				+ signed'({{(SUM_W - CW){p[a][CW-1]}}, p[a]});
			res[a] = sum_v[a][CW-1:0];
		end
	end

endmodule

[hdl/bcpe_ctrl.sv]
module bcpe_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bcpe_pkg::LEN_W-1:0]   n_pts,
	input  logic                         out_free,
	output bcpe_pkg::ctrl_t              ctrl
);

	localparam int LW = bcpe_pkg::LEN_W;
	localparam int IW = bcpe_pkg::IDX_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]    state_q;
	logic [LW-1:0] len_q;
	logic [IW-1:0] cnt_q;
	logic          last;

	// A pass over len_q points takes len_q-1 interpolations.
	assign last = (state_q == ST_RUN) && (LW'(cnt_q) == len_q - LW'(2));

	assign ctrl.idle = (state_q == ST_IDLE);
	assign ctrl.step = (state_q == ST_RUN);
	assign ctrl.last = last;
	assign ctrl.wr_idx = last ? IW'(len_q - LW'(2)) : IW'(len_q - LW'(1));
	assign ctrl.done = (state_q == ST_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q <= '0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						len_q <= n_pts;
						cnt_q <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (last) begin
						len_q <= len_q - LW'(1);
						cnt_q <= '0;
						if (len_q == LW'(2)) begin
							state_q <= ST_DONE;
						end
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> len_q >= LW'(2) && len_q <= LW'(bcpe_pkg::MAX_POINTS))
		else $error("point count out of range during reduction");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> LW'(cnt_q) <= len_q - LW'(2))
		else $error("interpolation counter ran past the end of a pass");

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && start |=> state_q == ST_RUN)
		else $error("evaluation did not start");

	a_done_pass: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && last && len_q == LW'(2) |=> state_q == ST_DONE)
		else $error("final pass did not finish the evaluation");

endmodule

[hdl/bezier_curve_point_evaluator.sv]
// Channel   Handshake                 Payload
// input     in_valid / in_ready       kind, point_index, coord_x/y/z, t_param
// output    out_valid / out_ready     curve_x, curve_y, curve_z
// config    cfg_wr_en (no wait)       cfg_wr_data = point_count
//
// Load items are taken back to back. An evaluate item runs n(n-1)/2
// interpolations for n points in use, one interpolation of all three axes per
// cycle through the shared interpolation unit; the next item is taken once the
// result is in the output register. Reset clears the sequencer, the output
// valid and sets point_count to 4; control points are undefined until loaded. A
// stalled output holds its result and blocks only the end of the next evaluation.
module bezier_curve_point_evaluator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic [2:0]                          point_index,
	input  logic signed [bcpe_pkg::COORD_W-1:0] coord_x,
	input  logic signed [bcpe_pkg::COORD_W-1:0] coord_y,
	input  logic signed [bcpe_pkg::COORD_W-1:0] coord_z,
	input  logic [bcpe_pkg::T_BITS-1:0]         t_param,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bcpe_pkg::COORD_W-1:0] curve_x,
	output logic signed [bcpe_pkg::COORD_W-1:0] curve_y,
	output logic signed [bcpe_pkg::COORD_W-1:0] curve_z,
	input  logic                                cfg_wr_en,
	input  logic [bcpe_pkg::PC_W-1:0]           cfg_wr_data
);

	localparam int MP = bcpe_pkg::MAX_POINTS;
	localparam int LW = bcpe_pkg::LEN_W;
	localparam int PW = bcpe_pkg::PC_W;

	bcpe_pkg::ctrl_t     ctrl;
	bcpe_pkg::coord_vec_t store_q [MP];
	bcpe_pkg::coord_vec_t w_q [MP];
	bcpe_pkg::coord_vec_t lerp_res;
	bcpe_pkg::coord_vec_t out_q;
	logic [PW-1:0]       pc_q;
	logic [LW-1:0]       n_pts;
	logic [bcpe_pkg::T_BITS-1:0] t_q;
	logic                out_valid_q;
	logic                accept;
	logic                start;
	logic                load;
	logic                out_free;

	assign in_ready = ctrl.idle;
	assign accept = in_valid && in_ready;
	assign start = accept && (kind == bcpe_pkg::KIND_EVAL);
	assign load = accept && (kind == bcpe_pkg::KIND_LOAD);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (pc_q < PW'(2)) begin
			n_pts = LW'(2);
		end else if (pc_q > PW'(MP)) begin
			n_pts = LW'(MP);
		end else begin
			n_pts = LW'(pc_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= bcpe_pkg::PC_RESET;
		end else if (cfg_wr_en) begin
			pc_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			store_q[point_index] <= {coord_z, coord_y, coord_x};
		end
		if (start) begin
			t_q <= t_param;
		end
	end

	bcpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.n_pts    (n_pts),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	bcpe_lerp u_lerp (
		.p   (w_q[0]),
		.q   (w_q[1]),
		.t   (t_q),
		.res (lerp_res)
	);

	// The working points form a queue: each step pops the head, and the new
	// point joins the tail. The last step of a pass also drops the old tail
	// point, which the next pass no longer needs.
	always_ff @(posedge clk) begin
		if (start) begin
			for (int k = 0; k < MP; k++) begin
				w_q[k] <= store_q[k];
			end
		end else if (ctrl.step) begin
			for (int k = 0; k < MP; k++) begin
				if (k == int'(ctrl.wr_idx)) begin
					w_q[k] <= lerp_res;
				end else if (ctrl.last) begin
					w_q[k] <= w_q[(k + 2) % MP];
				end else begin
					w_q[k] <= w_q[(k + 1) % MP];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.done && out_free) begin
			out_q <= w_q[0];
		end
	end

	assign out_valid = out_valid_q;
	assign curve_x = signed'(out_q[0]);
	assign curve_y = signed'(out_q[1]);
	assign curve_z = signed'(out_q[2]);

endmodule
